FILE: rtl/nonlinear_stencil_residual_assert.svh
// assertion macros shared by the residual block
`ifndef NONLINEAR_STENCIL_RESIDUAL_ASSERT_SVH
`define NONLINEAR_STENCIL_RESIDUAL_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NSR_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nonlinear_stencil_residual: assertion failed");

// next-cycle implication, checked out of reset
`define NSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nonlinear_stencil_residual: assertion failed");

`endif

FILE: rtl/nsr_pkg.sv
// types, constants and helpers of the stencil residual block
package nsr_pkg;

  localparam int FRAC_BITS = 24;

  // register indexes
  localparam logic [7:0] REG_LAMBDA = 8'd0;
  localparam logic [7:0] REG_MODE   = 8'd1;
  localparam logic [7:0] REG_POINTS = 8'd2;
  localparam logic [7:0] REG_STEP   = 8'd3;

  // fixed-point constants in Q2.30, pi squared in Q4.30
  localparam logic [31:0] PI_Q30    = 32'd3373259426;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [31:0] ONE30     = 32'h4000_0000;
  localparam logic [33:0] PI2_Q30   = 34'((64'(PI_Q30) * 64'(PI_Q30)) >> 30);

  localparam logic signed [69:0] S32_MAX_W = 70'sd2147483647;
  localparam logic signed [69:0] S32_MIN_W = -70'sd2147483648;

  // reciprocals floor((2^32-1)/d) for the divisor set
  localparam logic [31:0] RCP_1   = 32'hFFFF_FFFF;
  localparam logic [31:0] RCP_2   = 32'(64'hFFFF_FFFF / 64'd2);
  localparam logic [31:0] RCP_3   = 32'(64'hFFFF_FFFF / 64'd3);
  localparam logic [31:0] RCP_4   = 32'(64'hFFFF_FFFF / 64'd4);
  localparam logic [31:0] RCP_5   = 32'(64'hFFFF_FFFF / 64'd5);
  localparam logic [31:0] RCP_6   = 32'(64'hFFFF_FFFF / 64'd6);
  localparam logic [31:0] RCP_7   = 32'(64'hFFFF_FFFF / 64'd7);
  localparam logic [31:0] RCP_8   = 32'(64'hFFFF_FFFF / 64'd8);
  localparam logic [31:0] RCP_9   = 32'(64'hFFFF_FFFF / 64'd9);
  localparam logic [31:0] RCP_10  = 32'(64'hFFFF_FFFF / 64'd10);
  localparam logic [31:0] RCP_20  = 32'(64'hFFFF_FFFF / 64'd20);
  localparam logic [31:0] RCP_42  = 32'(64'hFFFF_FFFF / 64'd42);
  localparam logic [31:0] RCP_72  = 32'(64'hFFFF_FFFF / 64'd72);
  localparam logic [31:0] RCP_110 = 32'(64'hFFFF_FFFF / 64'd110);
  localparam logic [31:0] RCP_156 = 32'(64'hFFFF_FFFF / 64'd156);

  // result of one interior point
  typedef struct packed {
    logic signed [31:0] residual;
    logic signed [31:0] diag;
    logic               sat;
  } nsr_result_t;

  // clip to the signed 32-bit range, flag in the top bit
  function automatic logic [32:0] sat_clip(input logic signed [69:0] v);
    logic [32:0] r;
    if (v > S32_MAX_W) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < S32_MIN_W) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // reciprocal lookup for the small divisors
  function automatic logic [31:0] recip(input logic [7:0] d);
    logic [31:0] r;
    case (d)
      8'd1:    r = RCP_1;
      8'd2:    r = RCP_2;
      8'd3:    r = RCP_3;
      8'd4:    r = RCP_4;
      8'd5:    r = RCP_5;
      8'd6:    r = RCP_6;
      8'd7:    r = RCP_7;
      8'd8:    r = RCP_8;
      8'd9:    r = RCP_9;
      8'd10:   r = RCP_10;
      8'd20:   r = RCP_20;
      8'd42:   r = RCP_42;
      8'd72:   r = RCP_72;
      8'd110:  r = RCP_110;
      8'd156:  r = RCP_156;
      default: r = RCP_1;
    endcase
    return r;
  endfunction

  // sine series divisor (2j)(2j+1)
  function automatic logic [7:0] sin_div(input logic [3:0] j);
    logic [7:0] r;
    case (j)
      4'd6:    r = 8'd156;
      4'd5:    r = 8'd110;
      4'd4:    r = 8'd72;
      4'd3:    r = 8'd42;
      4'd2:    r = 8'd20;
      default: r = 8'd6;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/nsr_core.sv
// sequenced arithmetic core: one shared multiplier computes an interior point
module nsr_core import nsr_pkg::*; #(
  parameter int unsigned IDX_W = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] um_i,
  input  logic signed [31:0] ui_i,
  input  logic signed [31:0] up_i,
  input  logic [IDX_W-1:0]   idx_i,
  input  logic [30:0]        lambda_i,
  input  logic               mode_i,
  input  logic [23:0]        step_i,
  output logic               done_o,
  output nsr_result_t        result_o
);

  typedef enum logic [4:0] {
    C_IDLE, C_EXP0, C_EXP1, C_EXP2, C_EH_MUL, C_EH_DIV, C_DV0, C_DV1, C_DV2,
    C_EXPF, C_H2, C_HL, C_R, C_RES, C_SX, C_SZ, C_SZ2, C_SZ3, C_SH_MUL,
    C_SH_DIV, C_SFIN, C_SFIN2, C_PI2S, C_LE, C_CF, C_HC, C_DONE
  } core_state_e;

  localparam logic [FRAC_BITS:0] ONE_Q  = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS:0] HALF_Q = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [69:0] DIAG_TWO = 70'sd1 <<< (FRAC_BITS + 1);

  core_state_e        state_q;
  logic signed [69:0] prod_q;
  logic signed [31:0] exp_x_q;
  logic               exp_ret_q;
  logic signed [11:0] k_q;
  logic [29:0]        y_q;
  logic [31:0]        p_q;
  logic [3:0]         cnt_q;
  logic [31:0]        div_a_q;
  logic [7:0]         div_d_q;
  logic               div_sin_q;
  logic [31:0]        q0_q;
  logic [30:0]        e_q;
  logic [30:0]        es_q;
  logic signed [31:0] h2_q;
  logic signed [31:0] r_q;
  logic signed [35:0] res_q;
  logic               neg_q;
  logic [30:0]        z_q;
  logic [31:0]        z2_q;
  logic signed [31:0] pi2s_q;
  logic               sat_q;

  logic signed [34:0] op_a, op_b;
  logic signed [69:0] prod_d;
  logic [32:0]        mq;
  logic signed [31:0] mq_v;
  logic [32:0]        pi2s_c;
  logic signed [69:0] cf_w;
  logic [32:0]        cf_c;
  logic [31:0]        rem;
  logic [31:0]        quo;
  logic signed [12:0] sv;
  logic signed [12:0] nsv;
  logic [63:0]        wide;
  logic [30:0]        ev;
  logic               ev_sat;
  logic [FRAC_BITS:0] m0, m1, m2;
  logic               fold_neg;
  logic [31:0]        rr;
  logic signed [31:0] s_v;
  logic [32:0]        fin_res, fin_diag;

  // clipped product and derived terms
  assign mq     = sat_clip(prod_q >>> FRAC_BITS);
  assign mq_v   = mq[31:0];
  assign pi2s_c = sat_clip(prod_q >>> 30);
  assign cf_w   = 70'(pi2s_q) - 70'(mq_v);
  assign cf_c   = sat_clip(cf_w);

  // division correction after reciprocal estimate
  assign rem = div_a_q - prod_q[31:0];
  assign quo = q0_q + 32'(rem >= 32'(div_d_q)) + 32'(rem >= 32'({div_d_q, 1'b0}));

  // exponent scaling by 2^k
  always_comb begin
    sv     = 13'(k_q) + 13'(FRAC_BITS) - 13'sd30;
    nsv    = -sv;
    wide   = 64'(p_q) << sv[4:0];
    ev     = '0;
    ev_sat = 1'b0;
    if (!sv[12]) begin
      if (sv >= 13'sd31 || wide > 64'h7FFF_FFFF) begin
        ev     = 31'h7FFF_FFFF;
        ev_sat = 1'b1;
      end else begin
        ev = wide[30:0];
      end
    end else if (nsv < 13'sd32) begin
      ev = 31'(p_q >> nsv[4:0]);
    end
  end

  // sine argument reduction to [0, 0.5]
  always_comb begin
    m0       = prod_q[FRAC_BITS:0];
    fold_neg = (m0 >= ONE_Q);
    m1       = fold_neg ? (m0 - ONE_Q) : m0;
    m2       = (m1 > HALF_Q) ? (ONE_Q - m1) : m1;
  end

  // sine result with sign
  assign rr  = 32'(prod_q >> (60 - FRAC_BITS));
  assign s_v = neg_q ? -$signed(rr) : $signed(rr);

  // operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      C_EXP0:   begin op_a = 35'(exp_x_q); op_b = 35'(LOG2E_Q30); end
      C_EXP1:   begin op_a = 35'(prod_q[FRAC_BITS+29:FRAC_BITS]); op_b = 35'(LN2_Q30); end
      C_EH_MUL: begin op_a = 35'(y_q); op_b = 35'(p_q); end
      C_DV0:    begin op_a = 35'(div_a_q); op_b = 35'(recip(div_d_q)); end
      C_DV1:    begin op_a = 35'(prod_q[63:32]); op_b = 35'(div_d_q); end
      C_H2:     begin op_a = 35'(step_i); op_b = 35'(step_i); end
      C_HL:     begin op_a = 35'(mq_v); op_b = 35'(lambda_i); end
      C_R:      begin op_a = 35'(mq_v); op_b = 35'(e_q); end
      C_SX:     begin op_a = 35'(idx_i); op_b = 35'(step_i); end
      C_SZ:     begin op_a = 35'(m2) << (30 - FRAC_BITS); op_b = 35'(PI_Q30); end
      C_SZ2:    begin op_a = 35'(prod_q[60:30]); op_b = 35'(prod_q[60:30]); end
      C_SH_MUL: begin op_a = 35'(z2_q); op_b = 35'(p_q); end
      C_SFIN:   begin op_a = 35'(z_q); op_b = 35'(p_q); end
      C_SFIN2:  begin op_a = 35'(s_v); op_b = 35'(PI2_Q30); end
      C_LE:     begin op_a = 35'(lambda_i); op_b = 35'(es_q); end
      C_CF:     begin op_a = 35'(h2_q); op_b = 35'(signed'(cf_c[31:0])); end
      default:  begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod_d = op_a * op_b;

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= C_IDLE;
      prod_q    <= '0;
      exp_x_q   <= '0;
      exp_ret_q <= 1'b0;
      k_q       <= '0;
      y_q       <= '0;
      p_q       <= '0;
      cnt_q     <= '0;
      div_a_q   <= '0;
      div_d_q   <= 8'd1;
      div_sin_q <= 1'b0;
      q0_q      <= '0;
      e_q       <= '0;
      es_q      <= '0;
      h2_q      <= '0;
      r_q       <= '0;
      res_q     <= '0;
      neg_q     <= 1'b0;
      z_q       <= '0;
      z2_q      <= '0;
      pi2s_q    <= '0;
      sat_q     <= 1'b0;
    end else begin
      prod_q <= prod_d;
      case (state_q)
        C_IDLE: begin
          if (start_i) begin
            exp_x_q   <= ui_i;
            exp_ret_q <= 1'b0;
            sat_q     <= 1'b0;
            state_q   <= C_EXP0;
          end
        end
        C_EXP0: state_q <= C_EXP1;
        C_EXP1: begin
          k_q     <= 12'(prod_q >>> (FRAC_BITS + 30));
          p_q     <= ONE30;
          cnt_q   <= 4'd10;
          state_q <= C_EXP2;
        end
        C_EXP2: begin
          y_q     <= prod_q[59:30];
          state_q <= C_EH_MUL;
        end
        C_EH_MUL: state_q <= C_EH_DIV;
        C_EH_DIV: begin
          div_a_q   <= prod_q[61:30];
          div_d_q   <= 8'(cnt_q);
          div_sin_q <= 1'b0;
          state_q   <= C_DV0;
        end
        C_DV0: state_q <= C_DV1;
        C_DV1: begin
          q0_q    <= prod_q[63:32];
          state_q <= C_DV2;
        end
        C_DV2: begin
          cnt_q <= cnt_q - 4'd1;
          if (div_sin_q) begin
            p_q     <= ONE30 - quo;
            state_q <= (cnt_q == 4'd1) ? C_SFIN : C_SH_MUL;
          end else begin
            p_q     <= ONE30 + quo;
            state_q <= (cnt_q == 4'd1) ? C_EXPF : C_EH_MUL;
          end
        end
        C_EXPF: begin
          sat_q <= sat_q | ev_sat;
          if (exp_ret_q) begin
            es_q    <= ev;
            state_q <= C_LE;
          end else begin
            e_q     <= ev;
            state_q <= C_H2;
          end
        end
        C_H2: state_q <= C_HL;
        C_HL: begin
          h2_q    <= mq_v;
          sat_q   <= sat_q | mq[32];
          state_q <= C_R;
        end
        C_R: begin
          sat_q   <= sat_q | mq[32];
          state_q <= C_RES;
        end
        C_RES: begin
          r_q     <= mq_v;
          sat_q   <= sat_q | mq[32];
          res_q   <= (36'(ui_i) <<< 1) - 36'(up_i) - 36'(um_i) - 36'(mq_v);
          state_q <= mode_i ? C_SX : C_DONE;
        end
        C_SX: state_q <= C_SZ;
        C_SZ: begin
          neg_q   <= fold_neg;
          state_q <= C_SZ2;
        end
        C_SZ2: begin
          z_q     <= prod_q[60:30];
          state_q <= C_SZ3;
        end
        C_SZ3: begin
          z2_q    <= prod_q[61:30];
          p_q     <= ONE30;
          cnt_q   <= 4'd6;
          state_q <= C_SH_MUL;
        end
        C_SH_MUL: state_q <= C_SH_DIV;
        C_SH_DIV: begin
          div_a_q   <= prod_q[61:30];
          div_d_q   <= sin_div(cnt_q);
          div_sin_q <= 1'b1;
          state_q   <= C_DV0;
        end
        C_SFIN: state_q <= C_SFIN2;
        C_SFIN2: begin
          exp_x_q   <= s_v;
          exp_ret_q <= 1'b1;
          state_q   <= C_PI2S;
        end
        C_PI2S: begin
          pi2s_q  <= pi2s_c[31:0];
          sat_q   <= sat_q | pi2s_c[32];
          state_q <= C_EXP0;
        end
        C_LE: state_q <= C_CF;
        C_CF: begin
          sat_q   <= sat_q | mq[32] | cf_c[32];
          state_q <= C_HC;
        end
        C_HC: begin
          res_q   <= res_q - 36'(mq_v);
          sat_q   <= sat_q | mq[32];
          state_q <= C_DONE;
        end
        C_DONE: state_q <= C_IDLE;
        default: state_q <= C_IDLE;
      endcase
    end
  end

  // final clipping of residual and diagonal
  assign fin_res  = sat_clip(70'(res_q));
  assign fin_diag = sat_clip(DIAG_TWO - 70'(r_q));

  assign done_o            = (state_q == C_DONE);
  assign result_o.residual = fin_res[31:0];
  assign result_o.diag     = fin_diag[31:0];
  assign result_o.sat      = sat_q | fin_res[32] | fin_diag[32];

endmodule

FILE: rtl/nonlinear_stencil_residual.sv
// top level of the finite-difference residual block for the 1D Bratu problem
//
// Grid values of one sweep enter on the s_axis channel in index order, one
// signed Q8.24 item each. Results leave on m_axis: point index, residual and
// Jacobian diagonal in tdata, the clip flag in tuser, tlast on the final point.
// Point 0 gives a result at once, point 1 gives none, every later value gives
// the result of the interior point before it, and the final value adds its
// own boundary result.
// Point 0 goes out via T_PUTB, with s_axis_tready low there; point 1 only
// enters the history. An interior item is offered when the core is done; the
// single shared 35x35 multiplier runs the exp and sine series and the product
// chain. s_axis_tready is low meanwhile, and in T_PUTL when the final boundary
// result follows. Registers are written on the cfg channel (always ready); the
// user must write them only while the block idles; the block does not enforce
// it. Reset clears the history, the point counter and the output register and
// loads the register defaults. A stalled receiver holds the result in the
// output register; inputs are still taken while the block idles, and a new
// result waits in the sequencer until the slot frees.
`include "nonlinear_stencil_residual_assert.svh"
module nonlinear_stencil_residual import nsr_pkg::*; #(
  parameter int unsigned MAX_POINTS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // u_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // point_index, residual, jacobian_diag
  output logic        m_axis_tuser,   // saturated
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned CW   = $clog2(MAX_POINTS);
  localparam int unsigned NW0  = $clog2(MAX_POINTS + 1);
  localparam int unsigned NW   = (NW0 > 17) ? NW0 : 17;
  localparam logic [31:0] ONE_D = 32'(1) << FRAC_BITS;

  typedef enum logic [2:0] {T_IDLE, T_CALC, T_PUTI, T_PUTB, T_PUTL} top_state_e;

  top_state_e         state_q;
  logic [30:0]        lambda_q;
  logic               mode_q;
  logic [16:0]        grid_q;
  logic [23:0]        step_q;
  logic signed [31:0] prev_q, older_q, up_q, ui_q, um_q;
  logic [CW-1:0]      cnt_q, idx_q, kq_q;
  logic               last_q;
  logic               start_q;
  logic               out_valid_q;
  logic [79:0]        out_data_q;
  logic               out_user_q, out_last_q;

  logic               in_acc;
  logic               slot_free;
  logic               out_load;
  logic [NW-1:0]      n_raw, n_eff;
  logic               is_last;
  logic               core_done;
  nsr_result_t        core_res;

  // sweep length clamp and final-point detect
  always_comb begin
    n_raw = NW'(grid_q);
    if (n_raw < NW'(3)) begin
      n_eff = NW'(3);
    end else if (n_raw > NW'(MAX_POINTS)) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = n_raw;
    end
    is_last = (NW'(cnt_q) >= n_eff - NW'(1));
  end

  assign s_axis_tready = (state_q == T_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign out_load      = slot_free &&
                         (state_q == T_PUTI || state_q == T_PUTB || state_q == T_PUTL);
  assign cfg_ready_o   = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q <= 31'd16777216;
      mode_q   <= 1'b0;
      grid_q   <= 17'd9;
      step_q   <= 24'd2097152;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LAMBDA: lambda_q <= cfg_data_i[30:0];
        REG_MODE:   mode_q   <= cfg_data_i[0];
        REG_POINTS: grid_q   <= cfg_data_i[16:0];
        REG_STEP:   step_q   <= cfg_data_i[23:0];
        default:    ;
      endcase
    end
  end

  nsr_core #(
    .IDX_W (CW)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .um_i     (um_q),
    .ui_i     (ui_q),
    .up_i     (up_q),
    .idx_i    (idx_q),
    .lambda_i (lambda_q),
    .mode_i   (mode_q),
    .step_i   (step_q),
    .done_o   (core_done),
    .result_o (core_res)
  );

  // sweep control, history and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      prev_q      <= '0;
      older_q     <= '0;
      up_q        <= '0;
      ui_q        <= '0;
      um_q        <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      kq_q        <= '0;
      last_q      <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        T_IDLE: begin
          if (in_acc) begin
            older_q <= prev_q;
            prev_q  <= s_axis_tdata;
            up_q    <= s_axis_tdata;
            ui_q    <= prev_q;
            um_q    <= older_q;
            idx_q   <= cnt_q - CW'(1);
            kq_q    <= cnt_q;
            last_q  <= is_last;
            cnt_q   <= is_last ? '0 : cnt_q + CW'(1);
            if (cnt_q == '0) begin
              state_q <= T_PUTB;
            end else if (cnt_q != CW'(1)) begin
              start_q <= 1'b1;
              state_q <= T_CALC;
            end
          end
        end
        T_CALC: begin
          if (core_done) begin
            state_q <= T_PUTI;
          end
        end
        T_PUTI: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {core_res.diag, core_res.residual, 16'(idx_q)};
            out_user_q  <= core_res.sat;
            out_last_q  <= 1'b0;
            state_q     <= last_q ? T_PUTL : T_IDLE;
          end
        end
        T_PUTB, T_PUTL: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {ONE_D, up_q, 16'(kq_q)};
            out_user_q  <= 1'b0;
            out_last_q  <= (state_q == T_PUTL);
            state_q     <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  // checks on sequencing
  `NSR_ASSERT(done_only_in_calc, core_done, state_q == T_CALC)
  `NSR_ASSERT(counter_in_range, 1'b1, cnt_q <= CW'(MAX_POINTS - 1))
  `NSR_ASSERT_NEXT(interior_starts_core, in_acc && cnt_q >= CW'(2), state_q == T_CALC && start_q)

endmodule

FILE: sim/nonlinear_stencil_residual_tb.sv
// self-checking testbench of the finite-difference residual block
`timescale 1ns / 100ps

module nonlinear_stencil_residual_tb;
  import nsr_pkg::*;

  localparam int          WATCHDOG_LIMIT = 40000;
  localparam int          SETTLE_CYCLES  = 400;
  localparam int          HOLD_CYCLES    = 3000;
  localparam int          N_RANDOM       = 1780;
  localparam longint      Q_MAX          = 64'sd2147483647;
  localparam longint      Q_MIN          = -64'sd2147483648;
  localparam longint unsigned Q30        = 64'd1 << 30;
  localparam longint unsigned PI_C       = 64'd3373259426;
  localparam longint      LOG2E_C        = 64'sd1549082005;
  localparam longint unsigned LN2_C      = 64'd744261118;
  localparam logic [31:0] Q_ONE          = 32'h0100_0000;

  // one result item
  typedef struct {
    logic [15:0] idx;
    logic [31:0] res;
    logic [31:0] diag;
    logic        sat;
    logic        last;
  } point_t;

  // directed stimulus row, boundary result typed in where obvious
  typedef struct {
    logic [31:0] u;
    bit          typed;
    point_t      bnd;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  nonlinear_stencil_residual u_dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor copy of registers and history
  logic [30:0] lam_r;
  logic        mms_r;
  logic [16:0] npts_r;
  logic [23:0] h_r;
  logic [31:0] u_prev, u_older;
  int unsigned next_k;

  point_t residual_q[$];
  int     n_fail, n_items, n_results, n_interior_mms, idle_cnt;
  bit     hold_done;
  int     hold_cnt;
  int unsigned rx_cyc;

  function automatic longint clip_q(longint v, inout bit sat);
    if (v > Q_MAX) begin sat = 1; return Q_MAX; end
    if (v < Q_MIN) begin sat = 1; return Q_MIN; end
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b, inout bit sat);
    return clip_q((a * b) >>> FRAC_BITS, sat);
  endfunction

  function automatic longint exp_fx(logic signed [31:0] u, inout bit sat);
    longint t, k, s;
    longint unsigned f, y, p, v;
    t = longint'(u) * LOG2E_C;
    k = t >>> (FRAC_BITS + 30);
    f = longint'(t) & ((64'd1 << (FRAC_BITS + 30)) - 1);
    y = ((f >> FRAC_BITS) * LN2_C) >> 30;
    p = Q30;
    for (int d = 10; d >= 1; d--) p = Q30 + ((y * p) >> 30) / longint'(d);
    s = k + FRAC_BITS - 30;
    if (s >= 0) begin
      if (s >= 31 || p > (64'd2147483647 >> s)) begin sat = 1; return Q_MAX; end
      v = p << s;
    end else begin
      v = (-s >= 63) ? 64'd0 : (p >> (-s));
    end
    if (v > 64'd2147483647) begin sat = 1; return Q_MAX; end
    return longint'(v);
  endfunction

  function automatic longint sin_pi_fx(longint unsigned x);
    longint unsigned one, m, z, z2, p, r;
    bit neg;
    one = 64'd1 << FRAC_BITS;
    m = x & ((one << 1) - 1);
    neg = 0;
    p = Q30;
    if (m >= one) begin neg = 1; m -= one; end
    if (m > (one >> 1)) m = one - m;
    z = ((m << (30 - FRAC_BITS)) * PI_C) >> 30;
    z2 = (z * z) >> 30;
    for (int j = 6; j >= 1; j--) p = Q30 - ((z2 * p) >> 30) / longint'((2*j) * (2*j + 1));
    r = ((z * p) >> 30) >> (30 - FRAC_BITS);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic point_t interior_point(int unsigned idx, logic signed [31:0] um,
                                            logic signed [31:0] ui, logic signed [31:0] up);
    point_t o;
    bit sat;
    longint e, h2, hl, r, res, sv, pi2, pi2s, le, compf, diag;
    sat = 0;
    e = exp_fx(ui, sat);
    h2 = qmul(longint'(h_r), longint'(h_r), sat);
    hl = qmul(h2, longint'(lam_r), sat);
    r = qmul(hl, e, sat);
    res = -longint'(up) + 2 * longint'(ui) - longint'(um) - r;
    if (mms_r) begin
      sv = sin_pi_fx(longint'(idx) * longint'(h_r));
      pi2 = longint'((PI_C * PI_C) >> 30);
      pi2s = clip_q((pi2 * sv) >>> 30, sat);
      le = qmul(longint'(lam_r), exp_fx(sv[31:0], sat), sat);
      compf = clip_q(pi2s - le, sat);
      res -= qmul(h2, compf, sat);
    end
    res = clip_q(res, sat);
    diag = clip_q((64'sd1 << (FRAC_BITS + 1)) - r, sat);
    o.idx = idx[15:0]; o.res = res[31:0]; o.diag = diag[31:0]; o.sat = sat; o.last = 0;
    return o;
  endfunction

  // expected results of one accepted grid value
  task automatic predict_sweep(logic [31:0] v, output point_t pts[$]);
    int unsigned n, k;
    point_t b;
    pts = {};
    n = npts_r;
    k = next_k;
    if (n < 3) n = 3;
    if (n > 65536) n = 65536;
    if (k == 0) begin
      b.idx = 0; b.res = v; b.diag = Q_ONE; b.sat = 0; b.last = 0;
      pts.push_back(b);
    end else if (k >= 2) begin
      pts.push_back(interior_point(k - 1, u_older, u_prev, v));
      if (mms_r) n_interior_mms++;
    end
    if (k >= n - 1) begin
      b.idx = k[15:0]; b.res = v; b.diag = Q_ONE; b.sat = 0; b.last = 1;
      pts.push_back(b);
      next_k = 0;
    end else begin
      next_k = k + 1;
    end
    u_older = u_prev;
    u_prev = v;
  endtask

  // register write, mirrored into the predictor
  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    case (idx)
      REG_LAMBDA: lam_r  = data[30:0];
      REG_MODE:   mms_r  = data[0];
      REG_POINTS: npts_r = data[16:0];
      REG_STEP:   h_r    = data[23:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    wait (residual_q.size() == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // sender: bursts of items with random gaps
  int burst_left = 0;
  task automatic send_value(logic [31:0] u, bit typed = 0, point_t bnd = '{default: 0});
    int gap;
    point_t pts[$];
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= u;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    predict_sweep(u, pts);
    // typed boundary result stands in for the predicted one
    if (typed) begin
      if (bnd.last) pts[pts.size() - 1] = bnd;
      else pts[0] = bnd;
    end
    foreach (pts[i]) residual_q.push_back(pts[i]);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_u();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
    if (sel < 9) return $urandom();
    return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  // receiver stall pattern with one long hold-off
  always @(negedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && n_results >= 300) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (rx_cyc[9:8] == 2'd0) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 9) < 6);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    point_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (residual_q.size() == 0) begin
        $display("%0t: unexpected result idx %0d", $realtime, m_axis_tdata[15:0]);
        n_fail++;
      end else begin
        e = residual_q.pop_front();
        if (m_axis_tdata[15:0] !== e.idx) begin
          $display("%0t: point_index exp %0d got %0d", $realtime, e.idx, m_axis_tdata[15:0]);
          n_fail++;
        end
        if (m_axis_tdata[47:16] !== e.res) begin
          $display("%0t: residual idx %0d exp %h got %h", $realtime, e.idx, e.res,
                   m_axis_tdata[47:16]);
          n_fail++;
        end
        if (m_axis_tdata[79:48] !== e.diag) begin
          $display("%0t: jacobian_diag idx %0d exp %h got %h", $realtime, e.idx, e.diag,
                   m_axis_tdata[79:48]);
          n_fail++;
        end
        if (m_axis_tuser !== e.sat) begin
          $display("%0t: saturated idx %0d exp %b got %b", $realtime, e.idx, e.sat,
                   m_axis_tuser);
          n_fail++;
        end
        if (m_axis_tlast !== e.last) begin
          $display("%0t: last_of_sweep idx %0d exp %b got %b", $realtime, e.idx, e.last,
                   m_axis_tlast);
          n_fail++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cnt <= 0;
    end else if (rst_ni) begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", residual_q.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // directed rows: two default sweeps of nine points
  row_t rows[$];
  task automatic build_rows();
    logic [31:0] vals[18];
    row_t r;
    vals = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, Q_ONE, -Q_ONE, 32'h0400_0000,
             32'hFC00_0000, 32'h0080_0000, 32'h1234_5678,
             32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h0800_0000, 32'hF800_0000, 32'h0000_0001, 32'h7FFF_FFFF};
    foreach (vals[i]) begin
      r.u = vals[i];
      r.typed = (i % 9 == 0) || (i % 9 == 8);
      r.bnd.idx = (i % 9 == 0) ? 16'd0 : 16'd8;
      r.bnd.res = vals[i];
      r.bnd.diag = Q_ONE;
      r.bnd.sat = 0;
      r.bnd.last = (i % 9 == 8);
      rows.push_back(r);
    end
  endtask

  initial begin
    int unsigned n, per_phase;
    lam_r = 31'd16777216; mms_r = 0; npts_r = 17'd9; h_r = 24'd2097152;
    u_prev = 0; u_older = 0; next_k = 0;
    n_fail = 0; n_items = 0; n_results = 0; n_interior_mms = 0; idle_cnt = 0;
    hold_done = 0; hold_cnt = 0; rx_cyc = 0;
    build_rows();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed part after reset
    foreach (rows[i]) send_value(rows[i].u, rows[i].typed, rows[i].bnd);
    end_burst();
    wait_idle();

    // extremes of every register, unknown index ignored
    write_reg(REG_LAMBDA, 32'h7FFF_FFFF);
    write_reg(REG_STEP, 32'h0080_0000);
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_POINTS, 32'd0);
    write_reg(8'd7, 32'hFFFF_FFFF);
    repeat (3) send_value(rand_u());
    send_value(32'h7FFF_FFFF); send_value(32'h8000_0000); send_value(32'h0);
    end_burst();
    wait_idle();

    // grid size lowered mid-sweep
    write_reg(REG_LAMBDA, 32'h0);
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_POINTS, 32'd40);
    repeat (20) send_value(rand_u());
    end_burst();
    wait_idle();
    write_reg(REG_POINTS, 32'd6);
    repeat (4) send_value(rand_u());
    end_burst();
    wait_idle();
    write_reg(REG_POINTS, 32'd65536);
    write_reg(REG_STEP, 32'd0);
    repeat (10) send_value(rand_u());
    end_burst();
    wait_idle();
    write_reg(REG_POINTS, 32'h1FFFF);
    send_value(rand_u());
    end_burst();
    wait_idle();

    // random phases, mostly proper sweeps with matching step
    per_phase = 150;
    while (n_items < N_RANDOM) begin
      n = $urandom_range(3, 40);
      write_reg(REG_POINTS, n);
      write_reg(REG_STEP, ($urandom_range(0, 4) == 0) ? $urandom() : (32'h0100_0000 / (n - 1)));
      write_reg(REG_LAMBDA, ($urandom_range(0, 3) == 0) ? $urandom()
                                                       : $urandom_range(0, 32'h0400_0000));
      write_reg(REG_MODE, $urandom_range(0, 1));
      repeat (per_phase) send_value(rand_u());
      end_burst();
      wait_idle();
    end

    $display("%0d grid values sent, %0d results checked, %0d forced interior points",
             n_items, n_results, n_interior_mms);
    if (n_fail == 0 && residual_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", n_fail, residual_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
